### design/drle_pkg.sv
// Shared types, constants and the digit alphabet of the delta run-length text encoder.
`default_nettype none

package drle_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int RUN_LIMIT_DEF   = 63;
    localparam int RUN_BITS        = 6;
    localparam int DIGIT_BITS      = 6;
    localparam int CHAR_BITS       = 7;
    localparam int MAX_CHARS       = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 7'h2d;
    localparam logic [CHAR_BITS-1:0] CH_DOT     = 7'h2e;
    localparam logic [CHAR_BITS-1:0] CH_COLON   = 7'h3a;
    localparam logic [CHAR_BITS-1:0] CH_BANG    = 7'h21;
    localparam logic [CHAR_BITS-1:0] CH_STAR    = 7'h2a;
    localparam logic [CHAR_BITS-1:0] CH_DOLLAR  = 7'h24;
    localparam logic [CHAR_BITS-1:0] CH_UNDER   = 7'h5f;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 7'h61;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 7'h41;
    localparam logic [CHAR_BITS-1:0] CH_LPAREN  = 7'h28;
    localparam logic [CHAR_BITS-1:0] CH_RPAREN  = 7'h29;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               sequence_end;
    } in_payload_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] text_char;
        logic                 item_done;
    } out_payload_t;

    typedef struct packed {
        logic                 has_prefix;
        logic [CHAR_BITS-1:0] prefix;
        logic                 has_count;
        logic [RUN_BITS-1:0]  count;
        logic                 has_mag;
        logic                 item_last;
    } tok_ctrl_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PREFIX,
        PH_COUNT,
        PH_DIGIT
    } phase_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d inside {[6'd0:6'd9]}) begin
            c = CH_ZERO + {1'b0, d};
        end else if (d inside {[6'd10:6'd35]}) begin
            c = CH_LOWER_A + {1'b0, d} - 7'd10;
        end else if (d inside {[6'd36:6'd61]}) begin
            c = CH_UPPER_A + {1'b0, d} - 7'd36;
        end else if (d == 6'd62) begin
            c = CH_LPAREN;
        end else begin
            c = CH_RPAREN;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/delta_run_length_text_encoder_core.sv
// Top level of the delta run-length text encoder: front, token queue and back.
//
// Input channel s_: one request per integer of the sequence; sequence_end marks
// the last one, which flushes the held token and clears the state.
// Result channel m_: one request per ASCII character; item_done marks the last
// character that an input request causes. Requests that cause no character
// give no result.
// A taken request's token is written into the queue, then loaded into the back
// part's token registers; its characters leave through the output register.
// Throughput: one character per cycle while the receiver takes them and tokens
// are queued, set by the back part that steps through a token one character
// at a time. A request that closes one token and flushes another holds s_ready
// low until the second token is pushed into the queue.
// The front keeps taking requests while the back drains, up to a four-token
// queue between them. When the receiver stalls, the output register holds
// the character and the queue fills, then s_ready drops.
// Reset: synchronous, active low; clears the sequence state, the queue and
// the output register. No clearing pass is needed.
`default_nettype none

module delta_run_length_text_encoder_core
    import drle_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int RUN_LIMIT   = RUN_LIMIT_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  in_payload_t  s_payload,
    output logic         m_valid,
    input  logic         m_ready,
    output out_payload_t m_payload
);

    localparam int CTRL_W = $bits(tok_ctrl_t);
    localparam int QW     = CTRL_W + SAMPLE_BITS + 1;

    logic                 push_valid, q_full, q_pop, q_valid;
    tok_ctrl_t            push_ctrl, q_ctrl;
    logic [SAMPLE_BITS:0] push_delta, q_delta;
    logic [QW-1:0]        q_wdata, q_rdata;

    drle_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .RUN_LIMIT   (RUN_LIMIT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_ctrl  (push_ctrl),
        .push_delta (push_delta)
    );

    assign q_wdata = {push_ctrl, push_delta};

    drle_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push_valid),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rdata   (q_rdata)
    );

    assign q_ctrl  = tok_ctrl_t'(q_rdata[QW-1 -: CTRL_W]);
    assign q_delta = q_rdata[SAMPLE_BITS:0];

    drle_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ctrl    (q_ctrl),
        .q_delta   (q_delta),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !q_full)
        else $error("token pushed into a full queue");

    a_pop_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("token popped from an empty queue");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result request left valid after reset");

endmodule

`default_nettype wire

### design/drle_fifo.sv
// Short token queue between the front and back parts of the encoder.
`default_nettype none

module drle_fifo
    import drle_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign valid = (count_reg != '0);

endmodule

`default_nettype wire

### design/drle_front.sv
// Front part: accepts requests, tracks deltas and runs, and issues tokens to the queue.
`default_nettype none

module drle_front
    import drle_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int RUN_LIMIT   = RUN_LIMIT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_payload_t          s_payload,
    input  logic                 q_full,
    output logic                 push_valid,
    output tok_ctrl_t            push_ctrl,
    output logic [SAMPLE_BITS:0] push_delta
);

    localparam int DW = SAMPLE_BITS + 1;

    logic [SAMPLE_BITS-1:0] value;
    logic [DW-1:0]          value_ext, prev_ext, delta;
    logic                   accept, seq_end, extend, t1_exists;
    logic [DW-1:0]          t2_delta;
    logic [RUN_BITS-1:0]    t2_run;
    tok_ctrl_t              first_ctrl, t1_ctrl, t2_ctrl;

    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [DW-1:0]          pend_reg, pend_next;
    logic [RUN_BITS-1:0]    run_reg, run_next;
    logic                   seen_reg, seen_next;
    logic                   spill_valid_reg, spill_valid_next;
    tok_ctrl_t              spill_ctrl_reg, spill_ctrl_next;
    logic [DW-1:0]          spill_delta_reg, spill_delta_next;

    function automatic tok_ctrl_t make_tok(input logic [DW-1:0] d,
                                           input logic [RUN_BITS-1:0] n);
        tok_ctrl_t t;
        logic      zero;
        logic      neg;
        zero        = (d == '0);
        neg         = d[DW-1];
        t.has_prefix = 1'b1;
        t.has_count  = (n != RUN_BITS'(1));
        t.count      = n;
        t.has_mag    = !zero;
        t.item_last  = 1'b0;
        if (!t.has_count) begin
            t.prefix = zero ? CH_DOT : (neg ? CH_BANG : CH_COLON);
        end else begin
            t.prefix = zero ? CH_STAR : (neg ? CH_UNDER : CH_DOLLAR);
        end
        return t;
    endfunction

    assign value     = SAMPLE_BITS'({s_payload.sample_value});
    assign seq_end   = s_payload.sequence_end;
    assign value_ext = {value[SAMPLE_BITS-1], value};
    assign prev_ext  = {prev_reg[SAMPLE_BITS-1], prev_reg};
    assign delta     = value_ext - prev_ext;
    assign s_ready   = !spill_valid_reg && !q_full;
    assign accept    = s_valid && s_ready;

    assign extend    = (run_reg != '0) && (delta == pend_reg)
                       && (run_reg < RUN_BITS'(RUN_LIMIT));
    assign t1_exists = seen_reg && !extend && (run_reg != '0);
    assign t2_delta  = extend ? pend_reg : delta;
    assign t2_run    = extend ? run_reg + RUN_BITS'(1) : RUN_BITS'(1);

    always_comb begin
        first_ctrl            = '0;
        first_ctrl.has_prefix = value[SAMPLE_BITS-1];
        first_ctrl.prefix     = CH_MINUS;
        first_ctrl.has_mag    = 1'b1;
        first_ctrl.item_last  = 1'b1;

        t1_ctrl           = make_tok(pend_reg, run_reg);
        t1_ctrl.item_last = !seq_end;
        t2_ctrl           = make_tok(t2_delta, t2_run);
        t2_ctrl.item_last = 1'b1;
    end

    always_comb begin
        push_valid       = 1'b0;
        push_ctrl        = t1_ctrl;
        push_delta       = pend_reg;
        spill_valid_next = spill_valid_reg;
        spill_ctrl_next  = spill_ctrl_reg;
        spill_delta_next = spill_delta_reg;
        prev_next        = prev_reg;
        pend_next        = pend_reg;
        run_next         = run_reg;
        seen_next        = seen_reg;

        if (spill_valid_reg) begin
            push_valid = !q_full;
            push_ctrl  = spill_ctrl_reg;
            push_delta = spill_delta_reg;
            if (!q_full) begin
                spill_valid_next = 1'b0;
            end
        end else if (accept) begin
            if (!seen_reg) begin
                push_valid = 1'b1;
                push_ctrl  = first_ctrl;
                push_delta = value_ext;
            end else if (t1_exists) begin
                push_valid = 1'b1;
                if (seq_end) begin
                    spill_valid_next = 1'b1;
                    spill_ctrl_next  = t2_ctrl;
                    spill_delta_next = t2_delta;
                end
            end else if (seq_end) begin
                push_valid = 1'b1;
                push_ctrl  = t2_ctrl;
                push_delta = t2_delta;
            end
        end

        if (accept) begin
            prev_next = value;
            if (!seen_reg) begin
                seen_next = 1'b1;
            end else if (extend) begin
                run_next = t2_run;
            end else begin
                pend_next = delta;
                run_next  = RUN_BITS'(1);
            end
            if (seq_end) begin
                seen_next = 1'b0;
                run_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg         <= '0;
            seen_reg        <= 1'b0;
            spill_valid_reg <= 1'b0;
        end else begin
            run_reg         <= run_next;
            seen_reg        <= seen_next;
            spill_valid_reg <= spill_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg        <= prev_next;
        pend_reg        <= pend_next;
        spill_ctrl_reg  <= spill_ctrl_next;
        spill_delta_reg <= spill_delta_next;
    end

endmodule

`default_nettype wire

### design/drle_back.sv
// Back part: serialises queued tokens into characters behind an output register.
`default_nettype none

module drle_back
    import drle_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  tok_ctrl_t            q_ctrl,
    input  logic [SAMPLE_BITS:0] q_delta,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_payload_t         m_payload
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int NG = (DW + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int GW = $clog2(NG);
    localparam int PW = NG * DIGIT_BITS;
    localparam int CW = $clog2(MAX_CHARS);

    logic [DW-1:0]        head_mag;
    logic [PW-1:0]        head_pad;
    logic [GW-1:0]        head_top;
    phase_t               head_phase;
    logic                 emit_ok, emit, tok_end, item_end, trunc, load;
    logic [CHAR_BITS-1:0] cur_char;
    phase_t               step_phase;

    phase_t               phase_reg, phase_next;
    tok_ctrl_t            ctrl_reg, ctrl_next;
    logic [PW-1:0]        mag_reg, mag_next;
    logic [GW-1:0]        didx_reg, didx_next;
    logic [CW-1:0]        nchar_reg, nchar_next;
    logic                 drop_reg, drop_next;
    logic                 m_valid_reg, m_valid_next;
    out_payload_t         m_payload_reg, m_payload_next;

    assign head_mag = q_delta[DW-1] ? (~q_delta + DW'(1)) : q_delta;
    assign head_pad = PW'(head_mag);

    always_comb begin
        head_top = '0;
        for (int i = 0; i < NG; i++) begin
            if (head_pad[i*DIGIT_BITS +: DIGIT_BITS] != '0) begin
                head_top = GW'(i);
            end
        end
        if (q_ctrl.has_prefix) begin
            head_phase = PH_PREFIX;
        end else if (q_ctrl.has_count) begin
            head_phase = PH_COUNT;
        end else begin
            head_phase = PH_DIGIT;
        end
    end

    always_comb begin
        cur_char   = ctrl_reg.prefix;
        tok_end    = 1'b0;
        step_phase = PH_IDLE;
        case (phase_reg)
            PH_PREFIX: begin
                cur_char   = ctrl_reg.prefix;
                tok_end    = !ctrl_reg.has_count && !ctrl_reg.has_mag;
                step_phase = ctrl_reg.has_count ? PH_COUNT : PH_DIGIT;
            end
            PH_COUNT: begin
                cur_char   = digit_char(ctrl_reg.count);
                tok_end    = !ctrl_reg.has_mag;
                step_phase = PH_DIGIT;
            end
            PH_DIGIT: begin
                cur_char   = digit_char(mag_reg[didx_reg*DIGIT_BITS +: DIGIT_BITS]);
                tok_end    = (didx_reg == '0);
                step_phase = PH_DIGIT;
            end
            default: begin
                step_phase = PH_IDLE;
            end
        endcase
    end

    assign emit_ok  = !m_valid_reg || m_ready;
    assign emit     = (phase_reg != PH_IDLE) && emit_ok;
    assign item_end = tok_end && ctrl_reg.item_last;
    assign trunc    = (nchar_reg == CW'(MAX_CHARS - 1)) && !item_end;

    always_comb begin
        phase_next     = phase_reg;
        ctrl_next      = ctrl_reg;
        mag_next       = mag_reg;
        didx_next      = didx_reg;
        nchar_next     = nchar_reg;
        drop_next      = drop_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        q_pop          = 1'b0;
        load           = 1'b0;

        if (emit) begin
            m_valid_next             = 1'b1;
            m_payload_next.text_char = cur_char;
            m_payload_next.item_done = item_end || trunc;
            nchar_next = (item_end || trunc) ? '0 : nchar_reg + CW'(1);
            if (trunc) begin
                phase_next = PH_IDLE;
                drop_next  = !ctrl_reg.item_last;
            end else if (tok_end) begin
                phase_next = PH_IDLE;
                load       = q_valid;
            end else begin
                phase_next = step_phase;
                if (phase_reg == PH_DIGIT) begin
                    didx_next = didx_reg - GW'(1);
                end
            end
        end else if (phase_reg == PH_IDLE && q_valid) begin
            if (drop_reg) begin
                q_pop = 1'b1;
                if (q_ctrl.item_last) begin
                    drop_next = 1'b0;
                end
            end else begin
                load = 1'b1;
            end
        end

        if (load) begin
            q_pop      = 1'b1;
            phase_next = head_phase;
            ctrl_next  = q_ctrl;
            mag_next   = head_pad;
            didx_next  = head_top;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            nchar_reg   <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            nchar_reg   <= nchar_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ctrl_reg      <= ctrl_next;
        mag_reg       <= mag_next;
        didx_reg      <= didx_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire

### bench/delta_run_length_text_encoder_core_tb.sv
// Self-checking bench for the delta run-length text encoder core.
`timescale 1ns / 100ps

module delta_run_length_text_encoder_core_tb;
    import drle_pkg::*;

    localparam int RUN_LIMIT   = RUN_LIMIT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;
    localparam logic [8*64-1:0] DIGIT_ALPHABET =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ()";

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_valid   = 1'b0;
    logic         s_ready;
    in_payload_t  s_payload = '0;
    logic         m_valid;
    logic         m_ready   = 1'b0;
    out_payload_t m_payload;

    out_payload_t expected_chars[$];
    out_payload_t item_chars[$];
    out_payload_t expected_head;

    longint       last_sample;
    longint       held_delta;
    int           held_run;
    bit           first_written;

    int           send_idle_pct;
    int           recv_stall_pct;
    int           mismatch_count;
    int           cycle_count;

    delta_run_length_text_encoder_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [CHAR_BITS-1:0] base64_char(input logic [5:0] idx);
        return DIGIT_ALPHABET[8*(63-int'(idx)) +: CHAR_BITS];
    endfunction

    function automatic longint unsigned abs_value(input longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    function automatic void add_char(input logic [CHAR_BITS-1:0] c);
        out_payload_t p;
        p.text_char = c;
        p.item_done = 1'b0;
        if (item_chars.size() < MAX_CHARS) begin
            item_chars.insert(item_chars.size(), p);
        end
    endfunction

    function automatic void add_digits(input longint unsigned m);
        logic [CHAR_BITS-1:0] tmp [0:11];
        int n;
        n = 0;
        do begin
            tmp[n] = base64_char(m[5:0]);
            n++;
            m = m >> 6;
        end while (m != 0 && n < 12);
        while (n > 0) begin
            n--;
            add_char(tmp[n]);
        end
    endfunction

    function automatic void flush_held_token();
        if (held_run == 0) begin
            return;
        end
        if (held_run == 1) begin
            if (held_delta == 0) begin
                add_char(CH_DOT);
            end else begin
                add_char(held_delta > 0 ? CH_COLON : CH_BANG);
                add_digits(abs_value(held_delta));
            end
        end else begin
            if (held_delta == 0) begin
                add_char(CH_STAR);
                add_digits(held_run);
            end else begin
                add_char(held_delta > 0 ? CH_DOLLAR : CH_UNDER);
                add_digits(held_run);
                add_digits(abs_value(held_delta));
            end
        end
        held_run = 0;
    endfunction

    function automatic void clear_encoder_state();
        last_sample   = 0;
        held_delta    = 0;
        held_run      = 0;
        first_written = 1'b0;
    endfunction

    function automatic void predict_chars(input logic signed [31:0] sample, input bit last);
        longint value;
        longint d;
        value = sample;
        item_chars.delete();
        if (!first_written) begin
            if (value < 0) begin
                add_char(CH_MINUS);
            end
            add_digits(abs_value(value));
            first_written = 1'b1;
        end else begin
            d = value - last_sample;
            if (held_run != 0 && d == held_delta && held_run < RUN_LIMIT) begin
                held_run++;
            end else begin
                flush_held_token();
                held_delta = d;
                held_run   = 1;
            end
        end
        last_sample = value;
        if (last) begin
            flush_held_token();
            clear_encoder_state();
        end
        if (item_chars.size() > 0) begin
            item_chars[item_chars.size()-1].item_done = 1'b1;
        end
        foreach (item_chars[i]) begin
            expected_chars.insert(expected_chars.size(), item_chars[i]);
        end
    endfunction

    task automatic send_sample(input logic signed [31:0] sample, input bit last);
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid   = 1'b0;
            s_payload = {$urandom, 1'($urandom)};
            @(negedge aclk);
        end
        s_valid                = 1'b1;
        s_payload.sample_value = sample;
        s_payload.sequence_end = last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_chars(sample, last);
    endtask

    // hold or stall the result channel
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else begin
            m_ready = (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("unexpected character: got char %h done %b",
                             m_payload.text_char, m_payload.item_done);
                end
            end else begin
                expected_head = expected_chars[0];
                expected_chars.delete(0);
                if (m_payload.text_char !== expected_head.text_char ||
                    m_payload.item_done !== expected_head.item_done) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display({"character mismatch: expected char %h done %b,",
                                  " got char %h done %b"},
                                 expected_head.text_char, expected_head.item_done,
                                 m_payload.text_char, m_payload.item_done);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("delta_run_length_text_encoder_core: mismatch");
            $finish;
        end
    end

    function automatic logic signed [31:0] random_sample();
        case ($urandom_range(0, 6))
            0: return 32'sd0;
            1: return -32'sd1;
            2: return 32'sh7fffffff;
            3: return 32'sh80000000;
            4: return $signed($urandom_range(0, 200)) - 32'sd100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] random_step();
        case ($urandom_range(0, 7))
            0, 1: return 32'sd0;
            2, 3: return $signed($urandom_range(0, 128)) - 32'sd64;
            4: return $signed($urandom_range(0, 1 << 20)) - 32'sd524288;
            5: return ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000001;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_sequence(input int budget, output int sent);
        logic signed [31:0] cur;
        logic signed [31:0] step;
        int  nsegs;
        int  seg_len;
        bit  noisy;
        bit  closed;
        noisy  = ($urandom_range(0, 9) >= 8);
        closed = ($urandom_range(0, 9) != 0);
        nsegs  = $urandom_range(0, 4);
        cur    = random_sample();
        send_sample(cur, closed && nsegs == 0);
        sent = 1;
        for (int s = 0; s < nsegs; s++) begin
            step = random_step();
            if ($urandom_range(0, 9) == 0) begin
                seg_len = $urandom_range(60, 66);
            end else begin
                seg_len = $urandom_range(1, 5);
            end
            for (int k = 0; k < seg_len && sent < budget; k++) begin
                cur = noisy ? $urandom : cur + step;
                send_sample(cur, closed && s == nsegs - 1 && k == seg_len - 1);
                sent++;
            end
        end
    endtask

    task automatic test_single_values();
        send_sample(32'sd0, 1'b1);
        send_sample(-32'sd1, 1'b1);
        send_sample(32'sh7fffffff, 1'b1);
        send_sample(32'sh80000000, 1'b1);
    endtask

    task automatic test_single_step_tokens();
        send_sample(32'sd100, 1'b0);
        send_sample(32'sd100, 1'b0);
        send_sample(32'sd101, 1'b0);
        send_sample(32'sd101, 1'b0);
        send_sample(32'sd50, 1'b0);
        send_sample(32'sd50, 1'b1);
    endtask

    task automatic test_run_tokens();
        for (int i = 0; i < 4; i++) begin
            send_sample(32'sd7, i == 3);
        end
        for (int i = 0; i < 5; i++) begin
            send_sample(5 * i, i == 4);
        end
        for (int i = 0; i < 4; i++) begin
            send_sample(-3 * i, i == 3);
        end
    endtask

    task automatic test_extreme_deltas();
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh80000000, 1'b1);
    endtask

    task automatic test_random_sequences(input int idle_pct, input int stall_pct,
                                         input int item_target);
        int total;
        int sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        total = 0;
        while (total < item_target) begin
            send_sequence(item_target - total, sent);
            total += sent;
        end
    endtask

    initial begin
        clear_encoder_state();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_single_values();
        test_single_step_tokens();
        test_run_tokens();
        test_extreme_deltas();
        test_random_sequences(0, 0, 88);
        test_random_sequences(84, 0, 88);
        test_random_sequences(0, 84, 88);
        test_random_sequences(10, 10, 88);

        @(negedge aclk);
        s_valid = 1'b0;
        // drain outstanding characters
        while (expected_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("delta_run_length_text_encoder_core: match");
        end else begin
            $display("delta_run_length_text_encoder_core: mismatch");
        end
        $finish;
    end

endmodule

### delta_run_length_text_encoder_core.f
design/drle_pkg.sv
design/drle_fifo.sv
design/drle_front.sv
design/drle_back.sv
design/delta_run_length_text_encoder_core.sv
bench/delta_run_length_text_encoder_core_tb.sv
